// File: design/mmu_descriptor_search_unit_defines.svh
// Assertion macros shared by the descriptor search unit checker.
`ifndef MMU_DESCRIPTOR_SEARCH_UNIT_DEFINES_SVH
`define MMU_DESCRIPTOR_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define MSU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("descriptor search unit check failed");

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define MSU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("descriptor search unit check failed");

`endif

// File: design/msu_pkg.sv
// Shared types and constants for the descriptor search unit.
package msu_pkg;

	localparam int unsigned STATUS_W = 5;
	localparam int unsigned PSB_W    = 4;
	localparam logic [PSB_W-1:0] PSB_RESET = 4'd8;
	localparam logic [PSB_W-1:0] PAGE_SHIFT = 4'd8;
	localparam logic [14:0] LIMIT_MASK = 15'h7FFF;

	// Status bit positions
	localparam int unsigned ST_WP      = 0;
	localparam int unsigned ST_SUPER   = 1;
	localparam int unsigned ST_CI      = 2;
	localparam int unsigned ST_LIMIT   = 3;
	localparam int unsigned ST_INVALID = 4;

	typedef enum logic [2:0] {
		OP_CLEAR   = 3'd0,
		OP_ACCUM   = 3'd1,
		OP_LIMIT   = 3'd2,
		OP_INVALID = 3'd3,
		OP_QUERY   = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		ROLE_INVALID    = 3'd0,
		ROLE_PAGE       = 3'd1,
		ROLE_EARLY_PAGE = 3'd2,
		ROLE_TABLE      = 3'd3,
		ROLE_INDIRECT   = 3'd4
	} role_t;

	localparam logic [1:0] DT_INVALID = 2'd0;
	localparam logic [1:0] DT_PAGE    = 2'd1;
	localparam logic [1:0] DT_VALID4  = 2'd2;
	localparam logic [1:0] DT_VALID8  = 2'd3;

	// Input item, declared msb first so the last field lands in bit 0
	typedef struct packed {
		logic [3:0]  pad;
		logic        mod_bit_prior;
		logic        super_mode;
		logic        write_for_update;
		logic [23:0] page_field;
		logic [2:0]  descriptor_flags;
		logic [14:0] table_index;
		logic        is_lower_limit;
		logic [15:0] limit_field;
		logic        at_page_level;
		logic [1:0]  desc_type;
		logic [2:0]  opcode;
	} in_item_t;

	// Result item, declared msb first
	typedef struct packed {
		logic [6:0]          pad;
		logic [STATUS_W-1:0] search_status;
		logic                set_modified;
		logic                permits_access;
		logic                permits_write;
		logic [31:0]         page_base_address;
		logic                index_within_limit;
		logic                terminates;
		logic [3:0]          next_stride;
		logic [2:0]          role;
	} out_item_t;

	localparam int unsigned IN_W  = $bits(in_item_t);
	localparam int unsigned OUT_W = $bits(out_item_t);

endpackage

// File: design/msu_decode.sv
// Combinational status update and descriptor decode for one item.
module msu_decode
	import msu_pkg::*;
(
	input  in_item_t            item,
	input  logic [STATUS_W-1:0] status_cur,
	input  logic [PSB_W-1:0]    page_log2,
	output logic [STATUS_W-1:0] status_next,
	output out_item_t           result
);

	logic        fail;
	logic        wp;
	logic        sup_ok;
	logic [31:0] base;
	logic [31:0] align_mask;
	role_t       role;

	// Sticky status update, cleared by OP_CLEAR
	always_comb begin
		status_next = status_cur;
		unique case (item.opcode)
			OP_CLEAR:   status_next = '0;
			OP_ACCUM:   status_next = status_cur | {2'b00, item.descriptor_flags};
			OP_LIMIT:   status_next[ST_LIMIT] = 1'b1;
			OP_INVALID: status_next[ST_INVALID] = 1'b1;
			default:    status_next = status_cur;
		endcase
	end

	// Role from descriptor type and level
	always_comb begin
		unique case (item.desc_type)
			DT_INVALID: role = ROLE_INVALID;
			DT_PAGE:    role = item.at_page_level ? ROLE_PAGE : ROLE_EARLY_PAGE;
			default:    role = item.at_page_level ? ROLE_INDIRECT : ROLE_TABLE;
		endcase
	end

	// Page base, aligned when page size exceeds 256 bytes
	assign base       = {item.page_field, 8'h00};
	assign align_mask = ~((32'd1 << page_log2) - 32'd1);

	assign fail   = status_next[ST_LIMIT] | status_next[ST_INVALID];
	assign wp     = status_next[ST_WP];
	assign sup_ok = item.super_mode | ~status_next[ST_SUPER];

	always_comb begin
		result                    = '0;
		result.role               = role;
		result.next_stride        = (item.desc_type == DT_VALID4) ? 4'd4 :
		                            (item.desc_type == DT_VALID8) ? 4'd8 : 4'd0;
		result.terminates         = (role == ROLE_INVALID) || (role == ROLE_PAGE) ||
		                            (role == ROLE_EARLY_PAGE);
		result.index_within_limit = item.is_lower_limit ?
		                            (item.table_index >= (item.limit_field[14:0] & LIMIT_MASK)) :
		                            (item.table_index <= (item.limit_field[14:0] & LIMIT_MASK));
		result.page_base_address  = (page_log2 > PAGE_SHIFT) ? (base & align_mask) : base;
		result.permits_write      = ~fail & ~wp;
		result.permits_access     = ~fail & sup_ok;
		result.set_modified       = item.write_for_update & ~item.mod_bit_prior & ~wp &
		                            sup_ok & ~fail;
		result.search_status      = status_next;
	end

endmodule

// File: design/mmu_descriptor_search_unit.sv
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle unless stalled; status update and decode fit in one stage.
// Output back-pressure reaches s_axis_tready in the same cycle once both stages are full.
// Reset (arst_n low, asynchronous) empties both stages, clears the status to zero
// and sets the page size register to 8.
module mmu_descriptor_search_unit
	import msu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [PSB_W-1:0] cfg_wdata,     // log2 of the page size
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// [2:0] opcode, [4:3] desc_type, [5] at_page_level, [21:6] limit_field,
	// [22] is_lower_limit, [37:23] table_index, [40:38] descriptor_flags,
	// [64:41] page_field, [65] write_for_update, [66] super_mode,
	// [67] mod_bit_prior, [71:68] zero
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// [2:0] role, [6:3] next_stride, [7] terminates, [8] index_within_limit,
	// [40:9] page_base_address, [41] permits_write, [42] permits_access,
	// [43] set_modified, [48:44] search_status, [55:49] zero
	output logic [OUT_W-1:0] m_axis_tdata
);

	logic [PSB_W-1:0]    page_log2_q;
	logic [STATUS_W-1:0] status_q;
	logic [STATUS_W-1:0] status_next;
	logic                valid_s1;
	logic                valid_s2;
	in_item_t            item_s1;
	out_item_t           result;
	out_item_t           result_s2;
	logic                adv_s2;
	logic                adv_s1;

	// Pipeline flow control
	assign adv_s2        = ~valid_s2 | m_axis_tready;
	assign adv_s1        = valid_s1 & adv_s2;
	assign s_axis_tready = ~valid_s1 | adv_s2;

	msu_decode u_decode (
		.item        (item_s1),
		.status_cur  (status_q),
		.page_log2   (page_log2_q),
		.status_next (status_next),
		.result      (result)
	);

	// Control state: valids, status, configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			status_q    <= '0;
			page_log2_q <= PSB_RESET;
		end else begin
			if (cfg_we) begin
				page_log2_q <= cfg_wdata;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				status_q <= status_next;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= in_item_t'(s_axis_tdata);
		end
		if (adv_s1) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OUT_W'(result_s2);

endmodule

// File: design/msu_checker.sv
// Port-level checks for the descriptor search unit, bound to the top level.
`include "mmu_descriptor_search_unit_defines.svh"

module msu_checker
	import msu_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	out_item_t o;
	logic      out_stall;
	logic      wr_blocked;
	assign o = out_item_t'(m_axis_tdata);
	assign out_stall  = m_axis_tvalid && !m_axis_tready;
	assign wr_blocked = o.search_status[ST_WP] | o.search_status[ST_LIMIT] |
	                    o.search_status[ST_INVALID];

	// Stalled result holds
	`MSU_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

	// Terminating roles are exactly invalid, page and early page
	`MSU_ASSERT_NOW(a_term_role, m_axis_tvalid, o.terminates == (o.role <= ROLE_EARLY_PAGE))

	// Write permission means no protect, limit or invalid in status
	`MSU_ASSERT_NOW(a_pw_status, m_axis_tvalid && o.permits_write, !wr_blocked)

	// Setting modified requires both write and access permission
	`MSU_ASSERT_NOW(a_sm_perm, m_axis_tvalid && o.set_modified, o.permits_write && o.permits_access)

endmodule

bind mmu_descriptor_search_unit msu_checker u_msu_checker (.*);
